// File: rtl/cle_pkg.sv
package cle_pkg;

   // request codes
   typedef enum logic [2:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_END   = 3'd1,
      MODE_DEL_FRONT = 3'd2,
      MODE_DEL_AFTER = 3'd3,
      MODE_LIST      = 3'd4
   } mode_type;

   // answer codes
   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_LISTED    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_INS_NODE,
      S_INS_TAIL,
      S_DF_LINK,
      S_DA_CMP,
      S_DA_DEL,
      S_LS_EMIT,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] operand_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] element_value;
      logic               last_of_run;
   } rsp_type;

   // node store strobes
   typedef struct packed {
      logic rd_en;
      logic val_we;
      logic link_we;
   } ram_ctl_type;

endpackage

// File: rtl/cle_node_ram.sv
module cle_node_ram
   import cle_pkg::*;
#(
   parameter int unsigned POOL_DEPTH = 16
) (
   input  logic                          clock,
   input  ram_ctl_type                   ram_ctl,
   input  logic [$clog2(POOL_DEPTH)-1:0] wr_addr,
   input  logic signed [31:0]            wr_value,
   input  logic [$clog2(POOL_DEPTH)-1:0] wr_link,
   input  logic [$clog2(POOL_DEPTH)-1:0] rd_addr,
   output logic signed [31:0]            rd_value,
   output logic [$clog2(POOL_DEPTH)-1:0] rd_link
);

   localparam int unsigned IDX_W = $clog2(POOL_DEPTH);

   logic signed [31:0] value_mem [POOL_DEPTH];
   logic [IDX_W-1:0]   link_mem  [POOL_DEPTH];
   logic signed [31:0] rd_value_ff;
   logic [IDX_W-1:0]   rd_link_ff;

   always_ff @(posedge clock) begin
      if (ram_ctl.val_we) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (ram_ctl.link_we) begin
         link_mem[wr_addr] <= wr_link;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (ram_ctl.rd_en) begin
         rd_value_ff <= value_mem[rd_addr];
         rd_link_ff  <= link_mem[rd_addr];
      end
   end

   assign rd_value = rd_value_ff;
   assign rd_link  = rd_link_ff;

endmodule

// File: rtl/cle_ctrl.sv
module cle_ctrl
   import cle_pkg::*;
#(
   parameter int unsigned POOL_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  req_type                       req_word,
   input  logic                          slot_free,
   output logic                          rsp_load,
   output rsp_type                       rsp_next,
   output ram_ctl_type                   ram_ctl,
   output logic [$clog2(POOL_DEPTH)-1:0] wr_addr,
   output logic signed [31:0]            wr_value,
   output logic [$clog2(POOL_DEPTH)-1:0] wr_link,
   output logic [$clog2(POOL_DEPTH)-1:0] rd_addr,
   input  logic signed [31:0]            rd_value,
   input  logic [$clog2(POOL_DEPTH)-1:0] rd_link
);

   localparam int unsigned IDX_W = $clog2(POOL_DEPTH);
   localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [POOL_DEPTH-1:0] free_ff, free_in;
   logic [2:0]            mode_ff, mode_in;
   logic signed [31:0]    key_ff, key_in;
   logic [IDX_W-1:0]      cursor_ff, cursor_in;
   logic [IDX_W-1:0]      prev_ff, prev_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   status_type            status_ff, status_in;

   logic count_zero;
   logic count_one;
   logic count_full;
   logic key_hit;
   logic walk_last;

   assign count_zero = (count_ff == '0);
   assign count_one  = (count_ff == CNT_W'(1));
   assign count_full = (count_ff == CNT_W'(POOL_DEPTH));
   assign key_hit    = (rd_value == key_ff);
   assign walk_last  = ((step_ff + CNT_W'(1)) == count_ff);

   assign req_ready = (state_ff == S_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_word.mode)
                  MODE_INS_FRONT, MODE_INS_END: begin
                     state_in = count_full ? S_RESPOND : S_SCAN;
                  end
                  MODE_DEL_FRONT: begin
                     state_in = (count_zero || count_one) ? S_RESPOND : S_DF_LINK;
                  end
                  MODE_DEL_AFTER: begin
                     state_in = count_zero ? S_RESPOND : S_DA_CMP;
                  end
                  MODE_LIST: begin
                     state_in = count_zero ? S_RESPOND : S_LS_EMIT;
                  end
                  default: begin
                     state_in = S_RESPOND;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (free_ff[cursor_ff]) begin
               state_in = S_INS_NODE;
            end
         end
         S_INS_NODE: begin
            state_in = count_zero ? S_RESPOND : S_INS_TAIL;
         end
         S_INS_TAIL, S_DF_LINK, S_DA_DEL: begin
            state_in = S_RESPOND;
         end
         S_DA_CMP: begin
            if (key_hit) begin
               state_in = count_one ? S_RESPOND : S_DA_DEL;
            end else if (walk_last) begin
               state_in = S_RESPOND;
            end
         end
         S_LS_EMIT: begin
            if (slot_free && walk_last) begin
               state_in = S_IDLE;
            end
         end
         S_RESPOND: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and strobes
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      free_in   = free_ff;
      mode_in   = mode_ff;
      key_in    = key_ff;
      cursor_in = cursor_ff;
      prev_in   = prev_ff;
      step_in   = step_ff;
      status_in = status_ff;
      ram_ctl   = '0;
      wr_addr   = cursor_ff;
      wr_value  = key_ff;
      wr_link   = head_ff;
      rd_addr   = head_ff;
      rsp_load  = 1'b0;
      rsp_next  = '{status: status_ff, element_value: '0, last_of_run: 1'b1};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_word.mode;
               key_in    = req_word.operand_value;
               step_in   = '0;
               status_in = ST_DONE;
               case (req_word.mode)
                  MODE_INS_FRONT, MODE_INS_END: begin
                     cursor_in = '0;
                     if (count_full) begin
                        status_in = ST_FULL;
                     end
                  end
                  MODE_DEL_FRONT: begin
                     if (count_zero) begin
                        status_in = ST_EMPTY;
                     end else if (count_one) begin
                        free_in[head_ff] = 1'b1;
                        count_in         = '0;
                     end else begin
                        ram_ctl.rd_en = 1'b1;
                     end
                  end
                  MODE_DEL_AFTER: begin
                     cursor_in = head_ff;
                     if (count_zero) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ram_ctl.rd_en = 1'b1;
                     end
                  end
                  MODE_LIST: begin
                     if (count_zero) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ram_ctl.rd_en = 1'b1;
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!free_ff[cursor_ff]) begin
               cursor_in = cursor_ff + IDX_W'(1);
            end
         end
         S_INS_NODE: begin
            ram_ctl.val_we  = 1'b1;
            ram_ctl.link_we = 1'b1;
            wr_link         = count_zero ? cursor_ff : head_ff;
            if (count_zero) begin
               head_in            = cursor_ff;
               tail_in            = cursor_ff;
               free_in[cursor_ff] = 1'b0;
               count_in           = count_ff + CNT_W'(1);
            end
         end
         S_INS_TAIL: begin
            ram_ctl.link_we = 1'b1;
            wr_addr         = tail_ff;
            wr_link         = cursor_ff;
            if (mode_ff == MODE_INS_END) begin
               tail_in = cursor_ff;
            end else begin
               head_in = cursor_ff;
            end
            free_in[cursor_ff] = 1'b0;
            count_in           = count_ff + CNT_W'(1);
         end
         S_DF_LINK: begin
            // rd_link is the old head's successor
            ram_ctl.link_we  = 1'b1;
            wr_addr          = tail_ff;
            wr_link          = rd_link;
            head_in          = rd_link;
            free_in[head_ff] = 1'b1;
            count_in         = count_ff - CNT_W'(1);
         end
         S_DA_CMP: begin
            if (key_hit) begin
               if (count_one) begin
                  free_in[head_ff] = 1'b1;
                  count_in         = '0;
               end else begin
                  // fetch the victim to learn its successor
                  prev_in       = cursor_ff;
                  cursor_in     = rd_link;
                  rd_addr       = rd_link;
                  ram_ctl.rd_en = 1'b1;
               end
            end else if (walk_last) begin
               status_in = ST_NOT_FOUND;
            end else begin
               cursor_in     = rd_link;
               step_in       = step_ff + CNT_W'(1);
               rd_addr       = rd_link;
               ram_ctl.rd_en = 1'b1;
            end
         end
         S_DA_DEL: begin
            // cursor is the victim, prev its predecessor
            ram_ctl.link_we = 1'b1;
            wr_link         = rd_link;
            if (cursor_ff == head_ff) begin
               wr_addr = tail_ff;
               head_in = rd_link;
            end else begin
               wr_addr = prev_ff;
               if (cursor_ff == tail_ff) begin
                  tail_in = prev_ff;
               end
            end
            free_in[cursor_ff] = 1'b1;
            count_in           = count_ff - CNT_W'(1);
         end
         S_LS_EMIT: begin
            rsp_next = '{status: ST_LISTED, element_value: rd_value,
                         last_of_run: walk_last};
            if (slot_free) begin
               rsp_load = 1'b1;
               if (!walk_last) begin
                  step_in       = step_ff + CNT_W'(1);
                  rd_addr       = rd_link;
                  ram_ctl.rd_en = 1'b1;
               end
            end
         end
         S_RESPOND: begin
            rsp_load = slot_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         free_ff  <= '1;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      cursor_ff <= cursor_in;
      prev_ff   <= prev_in;
      step_ff   <= step_in;
      status_ff <= status_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POOL_DEPTH))
      else $error("element count beyond pool depth");

   a_free_balance: assert property (@(posedge clock) disable iff (reset)
      $countones(free_ff) == (POOL_DEPTH - count_ff))
      else $error("free map out of step with element count");

   a_single_node: assert property (@(posedge clock) disable iff (reset)
      count_one |-> (head_ff == tail_ff))
      else $error("single element but head and tail differ");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      !count_zero |-> !free_ff[head_ff])
      else $error("head node marked free");
`endif

endmodule

// File: rtl/circular_list_engine.sv
// Channel   Dir  Word       Accepted when
// req_      in   req_type   req_valid & req_ready
// rsp_      out  rsp_type   rsp_valid & rsp_ready
//
// One request at a time; req_ready is high only while the sequencer idles.
// Insert: free-map scan (one node a cycle), then the node write and, on a
// non-empty list, the tail link write; a full pool is answered without a scan.
// Delete after compares one node a cycle. List: one element per cycle
// while the response register is free, set by the single store read port.
// Synchronous reset empties the list at once; the node store needs no clear.
// A full response register stalls only the sequencer; a new request is
// taken while the last answer still waits.
module circular_list_engine
   import cle_pkg::*;
#(
   parameter int unsigned POOL_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int unsigned IDX_W = $clog2(POOL_DEPTH);

   ram_ctl_type        ram_ctl;
   logic [IDX_W-1:0]   wr_addr;
   logic signed [31:0] wr_value;
   logic [IDX_W-1:0]   wr_link;
   logic [IDX_W-1:0]   rd_addr;
   logic signed [31:0] rd_value;
   logic [IDX_W-1:0]   rd_link;

   logic    slot_free;
   logic    rsp_load;
   rsp_type rsp_next;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_word_ff, rsp_word_in;

   cle_ctrl #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .slot_free (slot_free),
      .rsp_load  (rsp_load),
      .rsp_next  (rsp_next),
      .ram_ctl   (ram_ctl),
      .wr_addr   (wr_addr),
      .wr_value  (wr_value),
      .wr_link   (wr_link),
      .rd_addr   (rd_addr),
      .rd_value  (rd_value),
      .rd_link   (rd_link)
   );

   cle_node_ram #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_node_ram (
      .clock    (clock),
      .ram_ctl  (ram_ctl),
      .wr_addr  (wr_addr),
      .wr_value (wr_value),
      .wr_link  (wr_link),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_link  (rd_link)
   );

   // output register: free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
